// ===== design/broadcast_ring_buffer_defines.svh =====
// Assertion helpers shared by the ring buffer RTL.
`ifndef BROADCAST_RING_BUFFER_DEFINES_SVH
`define BROADCAST_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring buffer check failed");

// Next-cycle implication.
`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring buffer check failed");

`else

`define BRB_ASSERT_IMPL(label, clk, rst, ante, cons)

`define BRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/brb_pkg.sv =====
`default_nettype none

package brb_pkg;

   localparam int COUNT_W = 64;
   localparam int TS_W    = 64;
   localparam int VAL_W   = 32;

   typedef enum logic {
      CMD_PRODUCE = 1'b0,
      CMD_CONSUME = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      ST_WRITTEN = 2'd0,
      ST_READ    = 2'd1,
      ST_EMPTY   = 2'd2
   } status_type;

   typedef struct packed {
      command_type        command;
      logic               reader_id;
      logic [TS_W-1:0]    in_time;
      logic [VAL_W-1:0]   in_value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               overrun;
      logic [TS_W-1:0]    out_time;
      logic [VAL_W-1:0]   out_value;
   } rsp_type;

   typedef struct packed {
      logic [TS_W-1:0]    sample_ts;
      logic [VAL_W-1:0]   sample_val;
   } sample_type;

   // Decision for one accepted item, handed from control to the datapath.
   typedef struct packed {
      logic               wr_en;
      logic               rd_en;
      status_type         status;
      logic               overrun;
   } issue_type;

endpackage

`default_nettype wire

// ===== design/broadcast_ring_buffer.sv =====
// A result passes through the registered memory read, kept in the memory stage, and
// then through the output register, from which it is offered.
// Throughput: one item per cycle; each item makes at most one access to the single-port
// sample memory, and the input stalls only while both stages are full and the result
// is stalled. Reset clears the write count and all reader counts; the sample store is
// not cleared, so an entry is meaningful only once it has been written.
`default_nettype none
`include "broadcast_ring_buffer_defines.svh"

module broadcast_ring_buffer #(
   parameter int DEPTH   = 1024,
   parameter int READERS = 2
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  brb_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output brb_pkg::rsp_type   rsp_data
);
   import brb_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic          req_accept;
   issue_type     issue;
   logic [AW-1:0] mem_addr;
   sample_type    wdata;
   sample_type    mem_rdata;

   // Memory stage: holds the decision while the read data arrives
   logic          s1_valid_ff, s1_valid_in;
   status_type    s1_status_ff, s1_status_in;
   logic          s1_overrun_ff, s1_overrun_in;
   logic          s1_move;

   // Output register
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff, out_data_in;

   // The memory stage may hand on when the output register is empty or being taken.
   // Stall the input only when both stages hold an item and the output is stalled,
   // so an item is still taken while one finished result waits.
   assign s1_move    = !out_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !s1_move;
   assign req_accept = req_valid && !req_stall;

   assign wdata = '{sample_ts: req_data.in_time, sample_val: req_data.in_value};

   brb_ctrl #(
      .DEPTH   (DEPTH),
      .READERS (READERS),
      .AW      (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .issue      (issue),
      .mem_addr   (mem_addr)
   );

   // Read data stays put between reads, so it needs no copy while the stage holds.
   brb_sample_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .wr_en (issue.wr_en),
      .rd_en (issue.rd_en),
      .addr  (mem_addr),
      .wdata (wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      s1_valid_in   = req_accept || (s1_valid_ff && !s1_move);
      s1_status_in  = req_accept ? issue.status  : s1_status_ff;
      s1_overrun_in = req_accept ? issue.overrun : s1_overrun_ff;
   end

   // Load the output from the memory stage; zero the sample unless it was a read.
   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      if (s1_valid_ff && s1_move) begin
         out_valid_in          = 1'b1;
         out_data_in.status    = s1_status_ff;
         out_data_in.overrun   = s1_overrun_ff;
         out_data_in.out_time  = '0;
         out_data_in.out_value = '0;
         if (s1_status_ff == ST_READ) begin
            out_data_in.out_time  = mem_rdata.sample_ts;
            out_data_in.out_value = mem_rdata.sample_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_status_ff  <= s1_status_in;
      s1_overrun_ff <= s1_overrun_in;
      out_data_ff   <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `BRB_ASSERT_IMPL(a_zero_unless_read, clock, reset, rsp_valid && rsp_data.status != ST_READ, rsp_data.out_time == 64'd0 && rsp_data.out_value == 32'd0)
   `BRB_ASSERT_IMPL(a_overrun_on_read, clock, reset, rsp_valid && rsp_data.overrun, rsp_data.status == ST_READ)
   `BRB_ASSERT_NEXT(a_s1_data_held, clock, reset, s1_valid_ff && s1_status_ff == ST_READ && !s1_move, $stable(mem_rdata))

endmodule

`default_nettype wire

// ===== design/brb_sample_mem.sv =====
`default_nettype none

module brb_sample_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire                   rd_en,
   input  wire  [AW-1:0]         addr,
   input  brb_pkg::sample_type   wdata,
   output brb_pkg::sample_type   rdata
);
   import brb_pkg::*;

   sample_type store_mem [DEPTH];
   sample_type rdata_ff;

   // Single port: write or read, read data registered and held until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= store_mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/brb_ctrl.sv =====
`default_nettype none
`include "broadcast_ring_buffer_defines.svh"

module brb_ctrl #(
   parameter int DEPTH   = 1024,
   parameter int READERS = 2,
   parameter int AW      = $clog2(DEPTH)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_accept,
   input  brb_pkg::req_type      req_data,
   output brb_pkg::issue_type    issue,
   output logic [AW-1:0]         mem_addr
);
   import brb_pkg::*;

   localparam int              RW         = (READERS > 1) ? $clog2(READERS) : 1;
   localparam logic            ONE_READER = (READERS == 1);
   localparam logic [AW-1:0]   LAST_SLOT  = AW'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] LAG_MAX = COUNT_W'(DEPTH);
   localparam logic [COUNT_W-1:0] LAG_ONE = COUNT_W'(DEPTH - 1);

   logic [COUNT_W-1:0] wcount_ff, wcount_in;
   logic [AW-1:0]      wslot_ff, wslot_in;
   logic [COUNT_W-1:0] rcount_ff [READERS];
   logic [COUNT_W-1:0] rcount_in [READERS];
   logic [AW-1:0]      rslot_ff  [READERS];
   logic [AW-1:0]      rslot_in  [READERS];

   logic               rid_ok;
   logic [RW-1:0]      rid;
   logic [COUNT_W-1:0] rd_cnt;
   logic [AW-1:0]      rd_slot;
   logic               empty;
   logic               skip;
   logic [COUNT_W-1:0] next_cnt;
   logic [AW-1:0]      base_slot;

   function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
      slot_inc = (s == LAST_SLOT) ? '0 : s + AW'(1);
   endfunction

   // Reader lookup and lag check; both candidate next counts are formed in parallel
   always_comb begin
      rid_ok    = !(ONE_READER && req_data.reader_id);
      rid       = rid_ok ? RW'(req_data.reader_id) : '0;
      rd_cnt    = rcount_ff[rid];
      rd_slot   = rslot_ff[rid];
      empty     = (rd_cnt >= wcount_ff);
      skip      = ((wcount_ff - rd_cnt) > LAG_MAX);
      next_cnt  = skip ? (wcount_ff - LAG_ONE) : (rd_cnt + COUNT_W'(1));
      base_slot = skip ? wslot_ff : rd_slot;
   end

   // Decide what the item does
   always_comb begin
      issue    = '{wr_en: 1'b0, rd_en: 1'b0, status: ST_EMPTY, overrun: 1'b0};
      mem_addr = wslot_ff;
      priority if (req_data.command == CMD_PRODUCE) begin
         issue.wr_en  = req_accept;
         issue.status = ST_WRITTEN;
      end else if (rid_ok && !empty) begin
         issue.rd_en   = req_accept;
         issue.status  = ST_READ;
         issue.overrun = skip;
         mem_addr      = base_slot;
      end else begin
         issue.status = ST_EMPTY;
      end
   end

   // Advance the counts
   always_comb begin
      wcount_in = wcount_ff;
      wslot_in  = wslot_ff;
      if (issue.wr_en) begin
         wcount_in = wcount_ff + COUNT_W'(1);
         wslot_in  = slot_inc(wslot_ff);
      end
      for (int i = 0; i < READERS; i++) begin
         rcount_in[i] = rcount_ff[i];
         rslot_in[i]  = rslot_ff[i];
         if (issue.rd_en && (RW'(i) == rid)) begin
            rcount_in[i] = next_cnt;
            rslot_in[i]  = slot_inc(base_slot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff <= '0;
         wslot_ff  <= '0;
         for (int i = 0; i < READERS; i++) begin
            rcount_ff[i] <= '0;
            rslot_ff[i]  <= '0;
         end
      end else begin
         wcount_ff <= wcount_in;
         wslot_ff  <= wslot_in;
         for (int i = 0; i < READERS; i++) begin
            rcount_ff[i] <= rcount_in[i];
            rslot_ff[i]  <= rslot_in[i];
         end
      end
   end

   `BRB_ASSERT_IMPL(a_wslot_range, clock, reset, 1'b1, wslot_ff <= LAST_SLOT)
   `BRB_ASSERT_IMPL(a_single_access, clock, reset, 1'b1, !(issue.rd_en && issue.wr_en))
   `BRB_ASSERT_NEXT(a_produce_advance, clock, reset, issue.wr_en, wcount_ff == $past(wcount_ff) + 64'd1)

endmodule

`default_nettype wire

// ===== tb/broadcast_ring_buffer_test.sv =====
`default_nettype none

module broadcast_ring_buffer_test;
   import brb_pkg::*;

   localparam int RING_DEPTH   = 1024;
   localparam int RING_READERS = 2;
   localparam int SLOT_W       = $clog2(RING_DEPTH);

   // Clock, reset and the block's inputs: all known from time zero.
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    rsp_stall = 1'b0;
   req_type req_data  = '0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   broadcast_ring_buffer #(
      .DEPTH   (RING_DEPTH),
      .READERS (RING_READERS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Shadow copy of the ring: sample store, producer count and one count per reader.
   logic [TS_W-1:0]    ring_time  [RING_DEPTH];
   logic [VAL_W-1:0]   ring_value [RING_DEPTH];
   logic [COUNT_W-1:0] write_total = '0;
   logic [COUNT_W-1:0] read_total [RING_READERS] = '{default: '0};

   // Results still owed by the block, oldest first.
   rsp_type     due_results[$];
   int unsigned mismatch_count = 0;

   // One row of the directed sequence; typed rows carry their own answer.
   typedef struct {
      req_type item;
      bit      typed;
      rsp_type answer;
   } probe_row;

   probe_row    probe_rows[$];
   int unsigned burst_left = 0;

   // Advance the shadow ring by one item and return the result it should give.
   function automatic rsp_type ring_access(input req_type item);
      rsp_type            res;
      logic [COUNT_W-1:0] rd;
      res        = '0;
      res.status = ST_EMPTY;
      if (item.command == CMD_PRODUCE) begin
         ring_time[write_total[SLOT_W-1:0]]  = item.in_time;
         ring_value[write_total[SLOT_W-1:0]] = item.in_value;
         write_total = write_total + COUNT_W'(1);
         res.status  = ST_WRITTEN;
      end else if (int'(item.reader_id) < RING_READERS) begin
         rd = read_total[item.reader_id];
         if (rd < write_total) begin
            // a reader more than a full ring behind skips to the oldest live sample
            if (write_total - rd > COUNT_W'(RING_DEPTH)) begin
               rd          = write_total - COUNT_W'(RING_DEPTH);
               res.overrun = 1'b1;
            end
            res.status    = ST_READ;
            res.out_time  = ring_time[rd[SLOT_W-1:0]];
            res.out_value = ring_value[rd[SLOT_W-1:0]];
            read_total[item.reader_id] = rd + COUNT_W'(1);
         end
      end
      return res;
   endfunction

   function automatic req_type make_req(input command_type cmd, input logic rid,
                                        input logic [TS_W-1:0] ts, input logic [VAL_W-1:0] val);
      req_type item;
      item.command   = cmd;
      item.reader_id = rid;
      item.in_time   = ts;
      item.in_value  = val;
      return item;
   endfunction

   function automatic req_type random_item(input command_type cmd);
      return make_req(cmd, 1'($urandom_range(0, 1)), {$urandom, $urandom}, $urandom);
   endfunction

   task automatic add_row(input command_type cmd, input logic rid,
                          input logic [TS_W-1:0] ts, input logic [VAL_W-1:0] val,
                          input bit typed, input status_type st = ST_EMPTY,
                          input logic [TS_W-1:0] got_ts = '0,
                          input logic [VAL_W-1:0] got_val = '0);
      probe_row row;
      row.item             = make_req(cmd, rid, ts, val);
      row.typed            = typed;
      row.answer           = '0;
      row.answer.status    = st;
      row.answer.out_time  = got_ts;
      row.answer.out_value = got_val;
      probe_rows.push_back(row);
   endtask

   // Offer one item and hold it until accepted. The sender runs in bursts:
   // at the end of each one drop valid for a random gap, sometimes none.
   task automatic push_item(input req_type item, input bit typed, input rsp_type answer);
      int unsigned gap;
      rsp_type     predicted;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = ring_access(item);
      due_results.push_back(typed ? answer : predicted);
   endtask

   // Random traffic in segments, each with its own produce/consume mix:
   // consume-heavy segments run readers dry, produce-heavy ones push them
   // towards overrun.
   task automatic mixed_traffic(input int unsigned count);
      int unsigned left;
      int unsigned span;
      int unsigned produce_pct;
      left = count;
      while (left != 0) begin
         span = $urandom_range(10, 80);
         if (span > left) span = left;
         case ($urandom_range(0, 2))
            0:       produce_pct = 20;
            1:       produce_pct = 50;
            default: produce_pct = 85;
         endcase
         repeat (span) begin
            push_item(random_item(($urandom_range(0, 99) < produce_pct) ?
                                  CMD_PRODUCE : CMD_CONSUME), 1'b0, '0);
         end
         left -= span;
      end
   endtask

   // Receiver: stall on a pattern of its own, switching between free running,
   // light and heavy stalling every so often.
   initial begin : rsp_stall_pattern
      int unsigned mode;
      int unsigned span;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(16, 200);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Compare each accepted result, field by field, with the oldest one owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected item: status %0d overrun %0b time %h value %h",
                        rsp_data.status, rsp_data.overrun, rsp_data.out_time,
                        rsp_data.out_value);
         end else begin
            want = due_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.overrun !== want.overrun ||
                rsp_data.out_time !== want.out_time ||
                rsp_data.out_value !== want.out_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want status %0d overrun %0b time %h value %h, got status %0d overrun %0b time %h value %h",
                           want.status, want.overrun, want.out_time, want.out_value,
                           rsp_data.status, rsp_data.overrun, rsp_data.out_time,
                           rsp_data.out_value);
            end
         end
      end
   end

   initial begin : stimulus
      logic rid;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed sequence: empty readers after reset, all-ones and all-zero
      // samples, produce ignoring reader_id, consume ignoring the payload.
      add_row(CMD_CONSUME, 1'b0, '1, '1, 1'b1, ST_EMPTY);
      add_row(CMD_CONSUME, 1'b1, '0, '0, 1'b1, ST_EMPTY);
      add_row(CMD_PRODUCE, 1'b0, '1, '1, 1'b1, ST_WRITTEN);
      add_row(CMD_PRODUCE, 1'b1, '0, '0, 1'b1, ST_WRITTEN);
      add_row(CMD_CONSUME, 1'b0, '0, '0, 1'b1, ST_READ, '1, '1);
      add_row(CMD_CONSUME, 1'b0, '1, '1, 1'b1, ST_READ, '0, '0);
      add_row(CMD_CONSUME, 1'b0, '1, '1, 1'b1, ST_EMPTY);
      add_row(CMD_CONSUME, 1'b1, '0, '0, 1'b1, ST_READ, '1, '1);
      add_row(CMD_PRODUCE, 1'b0, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1, ST_WRITTEN);
      add_row(CMD_CONSUME, 1'b1, '0, '0, 1'b1, ST_READ, '0, '0);
      add_row(CMD_CONSUME, 1'b1, '0, '0, 1'b1, ST_READ,
              64'h8000_0000_0000_0001, 32'h8000_0001);
      add_row(CMD_CONSUME, 1'b1, '0, '0, 1'b1, ST_EMPTY);
      add_row(CMD_PRODUCE, 1'b1, 64'h5555_5555_AAAA_AAAA, 32'hA5A5_5A5A, 1'b1, ST_WRITTEN);
      add_row(CMD_CONSUME, 1'b0, '0, '0, 1'b1, ST_READ,
              64'h8000_0000_0000_0001, 32'h8000_0001);
      add_row(CMD_CONSUME, 1'b0, '0, '0, 1'b1, ST_READ,
              64'h5555_5555_AAAA_AAAA, 32'hA5A5_5A5A);
      add_row(CMD_CONSUME, 1'b0, '0, '0, 1'b1, ST_EMPTY);
      add_row(CMD_PRODUCE, 1'b0, {$urandom, $urandom}, $urandom, 1'b0);
      add_row(CMD_PRODUCE, 1'b1, {$urandom, $urandom}, $urandom, 1'b0);
      add_row(CMD_CONSUME, 1'b1, '1, '0, 1'b0);
      add_row(CMD_CONSUME, 1'b0, '0, '1, 1'b0);
      foreach (probe_rows[i])
         push_item(probe_rows[i].item, probe_rows[i].typed, probe_rows[i].answer);

      mixed_traffic(400);

      // Overrun boundary: run both readers dry, then fill exactly one ring.
      // Reader 0 is then a full ring behind and reads the oldest sample
      // without skipping; one more sample puts reader 1 past the ring.
      for (int r = 0; r < RING_READERS; r++) begin
         rid = 1'(r);
         while (read_total[rid] != write_total)
            push_item(make_req(CMD_CONSUME, rid, {$urandom, $urandom}, $urandom), 1'b0, '0);
      end
      repeat (RING_DEPTH) push_item(random_item(CMD_PRODUCE), 1'b0, '0);
      push_item(make_req(CMD_CONSUME, 1'b0, '0, '0), 1'b0, '0);
      push_item(random_item(CMD_PRODUCE), 1'b0, '0);
      push_item(make_req(CMD_CONSUME, 1'b1, '0, '0), 1'b0, '0);
      repeat (3) begin
         push_item(make_req(CMD_CONSUME, 1'b1, {$urandom, $urandom}, $urandom), 1'b0, '0);
         push_item(make_req(CMD_CONSUME, 1'b0, {$urandom, $urandom}, $urandom), 1'b0, '0);
      end

      mixed_traffic(300);

      // Let the pipeline empty, then wait on for any stray item before reporting.
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0)
         $display("broadcast_ring_buffer_test: done, clean");
      else
         $display("broadcast_ring_buffer_test: done, errors");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin : watchdog
      #4000000;
      $display("broadcast_ring_buffer_test: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
